[hdl/csds_pkg.sv]
package csds_pkg;

   localparam int CYL_W       = 16;
   localparam int DIST_W      = 18;
   localparam int TOTAL_W     = 23;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 64;

   localparam logic [CYL_W-1:0] MAX_CYL_RESET = 16'd199;

   typedef logic [CYL_W-1:0] cyl_type;

   typedef enum logic [1:0] {
      S_LOAD,
      S_SCAN,
      S_WRAP
   } state_type;

   typedef struct packed {
      logic insert;
      logic shift;
   } cell_cmd_type;

   function automatic cyl_type clamp_cyl(input cyl_type value, input cyl_type top);
      return (value > top) ? top : value;
   endfunction

endpackage

[hdl/csds_cell.sv]
module csds_cell (
   input  logic                     clock,
   input  csds_pkg::cell_cmd_type   cmd,
   input  csds_pkg::cyl_type        ins_value,
   input  csds_pkg::cyl_type        left_value,
   input  logic                     left_gt,
   input  csds_pkg::cyl_type        right_value,
   input  logic                     own_valid,
   input  logic                     at_tail,
   output csds_pkg::cyl_type        value,
   output logic                     gt
);

   csds_pkg::cyl_type value_ff;
   csds_pkg::cyl_type value_in;

   assign value = value_ff;
   assign gt    = own_valid && (value_ff > ins_value);

   always_comb begin
      value_in = value_ff;
      if (cmd.insert) begin
         if (left_gt) begin
            value_in = left_value;
         end else if (gt || at_tail) begin
            value_in = ins_value;
         end
      end else if (cmd.shift) begin
         value_in = at_tail ? ins_value : right_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

[hdl/cscan_disk_request_scheduler_top.sv]
// Loading accepts one request transaction per cycle; the request channel then stalls for emission.
// After the last request, one request leaves the head of the cell chain per cycle while the
// response channel is free: requests below the head are moved to the tail first and are
// emitted in a wrap pass after the rest. Every request leaves through the single pop at cell
// zero. Reset is synchronous and active high; it clears control state and sets the top
// cylinder register to 199.
module cscan_disk_request_scheduler_top #(
   parameter int MAX_BATCH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Fields from bit 0: request_cylinder[15:0], head_position[31:16].
   input  logic [csds_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Fields from bit 0: serviced_cylinder[15:0], move_distance[33:16],
   // total_movement[56:34], zero fill[63:57].
   output logic [csds_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Fields from bit 0: wrapped.
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_wr_en,
   input  logic [csds_pkg::CYL_W-1:0]          csr_wr_data
);

   localparam int CNT_W  = $clog2(MAX_BATCH + 1);
   localparam int CYL_W  = csds_pkg::CYL_W;
   localparam int DIST_W = csds_pkg::DIST_W;
   localparam int TOT_W  = csds_pkg::TOTAL_W;
   localparam int PAD_W  = csds_pkg::RSP_TDATA_W - CYL_W - DIST_W - TOT_W;

   csds_pkg::state_type    state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [CNT_W-1:0]       recirc_ff, recirc_in;
   logic                   wrap_ff, wrap_in;
   logic [TOT_W-1:0]       total_ff, total_in;
   csds_pkg::cyl_type      max_cyl_ff, max_cyl_in;
   csds_pkg::cyl_type      head_ff, head_in;
   csds_pkg::cyl_type      pos_ff, pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   csds_pkg::cyl_type      rsp_cyl_ff;
   logic [DIST_W-1:0]      rsp_dist_ff;
   logic [TOT_W-1:0]       rsp_total_ff;
   logic                   rsp_wrap_ff;
   logic                   rsp_last_ff;

   csds_pkg::cell_cmd_type cmd;
   csds_pkg::cyl_type      cell_value [MAX_BATCH];
   logic [MAX_BATCH-1:0]   cell_gt;
   logic [MAX_BATCH-1:0]   cell_tail;
   logic [MAX_BATCH-1:0]   cell_valid;
   csds_pkg::cyl_type      ins_value;

   csds_pkg::cyl_type      req_cyl, req_head, head_now, pop_value, serv;
   logic                   accept, has_room, out_free, step, is_low, emit, recirc, last_out;
   logic [CNT_W-1:0]       recirc_next;
   logic [DIST_W-1:0]      move_dist;
   logic [TOT_W:0]         sum;
   logic [TOT_W-1:0]       total_sat;

   assign req_cyl   = req_tdata[CYL_W-1:0];
   assign req_head  = req_tdata[2*CYL_W-1:CYL_W];
   assign accept    = req_tvalid && req_tready;
   assign has_room  = count_ff < CNT_W'(MAX_BATCH);
   assign head_now  = (count_ff == '0) ? req_head : head_ff;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign pop_value = cell_value[0];
   assign step      = (state_ff != csds_pkg::S_LOAD) && out_free;
   assign is_low    = (state_ff == csds_pkg::S_SCAN) && (pop_value < pos_ff);
   assign emit      = step && !is_low;
   assign recirc    = step && is_low;
   assign recirc_next = recirc_ff + CNT_W'(recirc);
   assign serv      = csds_pkg::clamp_cyl(pop_value, max_cyl_ff);
   assign ins_value = (state_ff == csds_pkg::S_LOAD) ? req_cyl : pop_value;

   always_comb begin
      if ((state_ff == csds_pkg::S_WRAP) && wrap_ff) begin
         move_dist = ({2'b00, max_cyl_ff} - {2'b00, pos_ff}) + {2'b00, max_cyl_ff}
                   + {2'b00, serv};
      end else begin
         move_dist = {2'b00, serv} - {2'b00, pos_ff};
      end
   end

   assign sum       = {1'b0, total_ff} + {{(TOT_W + 1 - DIST_W){1'b0}}, move_dist};
   assign total_sat = sum[TOT_W] ? {TOT_W{1'b1}} : sum[TOT_W-1:0];
   assign last_out  = (scan_ff == CNT_W'(1))
                   && ((state_ff == csds_pkg::S_WRAP) || (recirc_ff == '0));

   genvar gi;
   generate
      for (gi = 0; gi < MAX_BATCH; gi++) begin : g_cell
         assign cell_valid[gi] = count_ff > CNT_W'(gi);
         assign cell_tail[gi]  = cmd.insert ? (count_ff == CNT_W'(gi))
                                            : (recirc && (count_ff == CNT_W'(gi + 1)));
         csds_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .ins_value   (ins_value),
            .left_value  ((gi == 0) ? cell_value[0] : cell_value[(gi == 0) ? 0 : gi - 1]),
            .left_gt     ((gi == 0) ? 1'b0 : cell_gt[(gi == 0) ? 0 : gi - 1]),
            .right_value ((gi == MAX_BATCH - 1) ? cell_value[gi]
                          : cell_value[(gi == MAX_BATCH - 1) ? gi : gi + 1]),
            .own_valid   (cell_valid[gi]),
            .at_tail     (cell_tail[gi]),
            .value       (cell_value[gi]),
            .gt          (cell_gt[gi])
         );
      end
   endgenerate

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         csds_pkg::S_LOAD: begin
            if (accept && req_tlast) begin
               state_in = csds_pkg::S_SCAN;
            end
         end
         csds_pkg::S_SCAN: begin
            if (step && (scan_ff == CNT_W'(1))) begin
               state_in = (recirc_next != '0) ? csds_pkg::S_WRAP : csds_pkg::S_LOAD;
            end
         end
         csds_pkg::S_WRAP: begin
            if (step && (scan_ff == CNT_W'(1))) begin
               state_in = csds_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = csds_pkg::S_LOAD;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         csds_pkg::S_LOAD: begin
            req_tready = 1'b1;
            cmd.insert = req_tvalid && has_room;
         end
         csds_pkg::S_SCAN, csds_pkg::S_WRAP: begin
            cmd.shift = step;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      scan_in      = scan_ff;
      recirc_in    = recirc_ff;
      wrap_in      = wrap_ff;
      total_in     = total_ff;
      head_in      = head_ff;
      pos_in       = pos_ff;
      max_cyl_in   = csr_wr_en ? csr_wr_data : max_cyl_ff;
      rsp_valid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      case (state_ff)
         csds_pkg::S_LOAD: begin
            if (accept) begin
               head_in  = head_now;
               count_in = count_ff + CNT_W'(has_room);
               if (req_tlast) begin
                  scan_in   = count_ff + CNT_W'(has_room);
                  recirc_in = '0;
                  pos_in    = csds_pkg::clamp_cyl(head_now, max_cyl_ff);
               end
            end
         end
         csds_pkg::S_SCAN: begin
            if (step) begin
               scan_in   = scan_ff - CNT_W'(1);
               recirc_in = recirc_next;
               if (emit) begin
                  pos_in   = serv;
                  total_in = total_sat;
               end
               if (scan_ff == CNT_W'(1)) begin
                  if (recirc_next != '0) begin
                     scan_in = recirc_next;
                     wrap_in = 1'b1;
                  end else begin
                     count_in = '0;
                     total_in = '0;
                  end
               end
            end
         end
         csds_pkg::S_WRAP: begin
            if (step) begin
               scan_in  = scan_ff - CNT_W'(1);
               wrap_in  = 1'b0;
               pos_in   = serv;
               total_in = total_sat;
               if (scan_ff == CNT_W'(1)) begin
                  count_in = '0;
                  total_in = '0;
               end
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= csds_pkg::S_LOAD;
         count_ff     <= '0;
         scan_ff      <= '0;
         recirc_ff    <= '0;
         wrap_ff      <= 1'b0;
         total_ff     <= '0;
         max_cyl_ff   <= csds_pkg::MAX_CYL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         recirc_ff    <= recirc_in;
         wrap_ff      <= wrap_in;
         total_ff     <= total_in;
         max_cyl_ff   <= max_cyl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      pos_ff  <= pos_in;
      if (emit) begin
         rsp_cyl_ff   <= serv;
         rsp_dist_ff  <= move_dist;
         rsp_total_ff <= total_sat;
         rsp_wrap_ff  <= (state_ff == csds_pkg::S_WRAP) && wrap_ff;
         rsp_last_ff  <= last_out;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_total_ff, rsp_dist_ff, rsp_cyl_ff};
   assign rsp_tuser  = rsp_wrap_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BATCH))
      else $error("Request count exceeds the batch size.");

   a_wrap_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csds_pkg::S_WRAP) |-> (scan_ff != '0))
      else $error("Wrap pass entered with no requests left.");

   a_batch_cleared: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == csds_pkg::S_LOAD) && ($past(state_ff) != csds_pkg::S_LOAD))
      |-> ((count_ff == '0) && (total_ff == '0)))
      else $error("Batch state not cleared after emission.");

   a_total_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == csds_pkg::S_WRAP) |-> (total_ff >= $past(total_ff)))
      else $error("Running total decreased during emission.");

endmodule
